// ----- sv/hpel_pkg.sv -----
package hpel_pkg;

	localparam int unsigned SLOTS_PER_BLOCK_DEF = 16;
	localparam int unsigned BLOCK_COUNT_DEF     = 7;

	localparam int unsigned REQ_W   = 3;
	localparam int unsigned HOUR_W  = 32;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned REC_W   = TIME_W + VALUE_W + 3 * BYTE_W;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [1:0] REG_CHANNEL_MODE = 2'd0;
	localparam logic [1:0] REG_FIXED_TYPE   = 2'd1;
	localparam logic [1:0] REG_RECORD_LIMIT = 2'd2;

	localparam logic [COUNT_W-1:0] RECORD_LIMIT_RST = 7'd100;
	localparam logic [BYTE_W-1:0]  TEMP_CELL        = 8'hFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_UPDATE = 3'd0,
		REQ_FORCED = 3'd1,
		REQ_COMMIT = 3'd2,
		REQ_READ   = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic do_sample;
		logic do_commit;
		logic do_clear;
		logic walk_init;
		logic walk_step;
		logic walk_count;
		logic rd_issue;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		req_t req;
		logic sample_take;
		logic commit_ok;
		logic in_range;
		logic cur_used;
		logic hit;
		logic walk_last;
	} dp_sts_t;

endpackage

// ----- sv/hpel_ram.sv -----
module hpel_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/hpel_ctrl.sv -----
module hpel_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  hpel_pkg::dp_sts_t sts,
	output hpel_pkg::dp_cmd_t cmd
);

	hpel_pkg::state_t state_q;
	hpel_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != hpel_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hpel_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			hpel_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = hpel_pkg::ST_DISPATCH;
				end
			end
			hpel_pkg::ST_DISPATCH: begin
				state_d = hpel_pkg::ST_FINISH;
				unique case (sts.req)
					hpel_pkg::REQ_UPDATE: cmd.do_sample = sts.sample_take;
					hpel_pkg::REQ_FORCED: cmd.do_sample = 1'b1;
					hpel_pkg::REQ_COMMIT: cmd.do_commit = sts.commit_ok;
					hpel_pkg::REQ_READ: begin
						if (sts.in_range) begin
							cmd.walk_init = 1'b1;
							state_d       = hpel_pkg::ST_WALK;
						end
					end
					hpel_pkg::REQ_CLEAR:  cmd.do_clear = 1'b1;
					default: ;
				endcase
			end
			hpel_pkg::ST_WALK: begin
				if (sts.cur_used && sts.hit) begin
					cmd.rd_issue = 1'b1;
					state_d      = hpel_pkg::ST_FINISH;
				end else if (sts.walk_last) begin
					state_d = hpel_pkg::ST_FINISH;
				end else begin
					cmd.walk_step  = 1'b1;
					cmd.walk_count = sts.cur_used;
				end
			end
			hpel_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = hpel_pkg::ST_IDLE;
				end
			end
			default: state_d = hpel_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- sv/hpel_dp.sv -----
module hpel_dp #(
	parameter int unsigned SLOTS_PER_BLOCK = hpel_pkg::SLOTS_PER_BLOCK_DEF,
	parameter int unsigned BLOCK_COUNT     = hpel_pkg::BLOCK_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hpel_pkg::dp_cmd_t                 cmd,
	output hpel_pkg::dp_sts_t                 sts,
	input  logic                              channel_mode,
	input  logic [hpel_pkg::BYTE_W-1:0]       fixed_event_type,
	input  logic [hpel_pkg::COUNT_W-1:0]      record_limit,
	input  logic [hpel_pkg::REQ_W-1:0]        req_type,
	input  logic [hpel_pkg::HOUR_W-1:0]       hour_id,
	input  logic [hpel_pkg::VALUE_W-1:0]      sample_value,
	input  logic [hpel_pkg::BYTE_W-1:0]       sample_tag,
	input  logic [hpel_pkg::BYTE_W-1:0]       charge_state,
	input  logic [hpel_pkg::TIME_W-1:0]       commit_time,
	input  logic [hpel_pkg::INDEX_W-1:0]      read_index,
	output logic                              done_res,
	output logic [hpel_pkg::TIME_W-1:0]       rec_time,
	output logic [hpel_pkg::VALUE_W-1:0]      rec_value,
	output logic [hpel_pkg::BYTE_W-1:0]       rec_type,
	output logic [hpel_pkg::BYTE_W-1:0]       rec_cell,
	output logic [hpel_pkg::BYTE_W-1:0]       rec_charge,
	output logic [hpel_pkg::COUNT_W-1:0]      stored_count,
	output logic                              peak_pending
);

	localparam int unsigned TOTAL  = SLOTS_PER_BLOCK * BLOCK_COUNT;
	localparam int unsigned SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int unsigned BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int unsigned OFF_W  = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
	localparam int unsigned RW     = hpel_pkg::REC_W;
	localparam int unsigned BW     = hpel_pkg::BYTE_W;

	logic [hpel_pkg::REQ_W-1:0]   req_q;
	logic [hpel_pkg::HOUR_W-1:0]  hour_in_q;
	logic [hpel_pkg::VALUE_W-1:0] value_in_q;
	logic [BW-1:0]                tag_in_q;
	logic [BW-1:0]                charge_in_q;
	logic [hpel_pkg::TIME_W-1:0]  time_in_q;
	logic [hpel_pkg::INDEX_W-1:0] index_in_q;

	logic [hpel_pkg::HOUR_W-1:0]  cur_hour_q;
	logic [hpel_pkg::VALUE_W-1:0] peak_value_q;
	logic [BW-1:0]                peak_tag_q;
	logic [BW-1:0]                peak_charge_q;
	logic                         pending_q;
	logic [SLOT_W-1:0]            wr_slot_q;
	logic [BLK_W-1:0]             wr_blk_q;
	logic [OFF_W-1:0]             wr_off_q;
	logic [hpel_pkg::COUNT_W-1:0] count_q;
	logic [TOTAL-1:0]             used_q;
	logic [TOTAL-1:0]             used_d;
	logic [TOTAL-1:0]             in_blk;
	logic [SLOT_W-1:0]            walk_q;
	logic [SLOT_W-1:0]            step_q;
	logic [hpel_pkg::INDEX_W-1:0] found_q;
	logic                         done_q;

	logic [BW-1:0]                rec_type_w;
	logic [BW-1:0]                rec_cell_w;
	logic [RW-1:0]                ram_wdata;
	logic [RW-1:0]                ram_rdata;
	logic                         rec_sel;

	for (genvar i = 0; i < TOTAL; i++) begin : g_blk
		localparam int unsigned BLK_I = i / SLOTS_PER_BLOCK;
		assign in_blk[i] = (wr_blk_q == BLK_W'(BLK_I));
	end

	always_comb begin
		used_d = used_q;
		if (cmd.do_clear) begin
			used_d = '0;
		end else if (cmd.do_commit) begin
			if (used_q[wr_slot_q]) begin
				used_d = used_q & ~in_blk;
			end
			used_d[wr_slot_q] = 1'b1;
		end
	end

	assign rec_type_w = channel_mode ? peak_tag_q : fixed_event_type;
	assign rec_cell_w = channel_mode ? hpel_pkg::TEMP_CELL : peak_tag_q;
	assign ram_wdata  = {time_in_q, peak_value_q, rec_type_w, rec_cell_w, peak_charge_q};

	hpel_ram #(
		.WIDTH (RW),
		.DEPTH (TOTAL)
	) u_store (
		.clk   (clk),
		.we    (cmd.do_commit),
		.waddr (wr_slot_q),
		.wdata (ram_wdata),
		.re    (cmd.rd_issue),
		.raddr (walk_q),
		.rdata (ram_rdata)
	);

	assign sts.req         = hpel_pkg::req_t'(req_q);
	assign sts.sample_take = (hour_in_q != cur_hour_q) || (value_in_q > peak_value_q);
	assign sts.commit_ok   = pending_q && (count_q < record_limit);
	assign sts.in_range    = (index_in_q < {1'b0, count_q});
	assign sts.cur_used    = used_q[walk_q];
	assign sts.hit         = (found_q == index_in_q);
	assign sts.walk_last   = (step_q == SLOT_W'(TOTAL - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q       <= req_type;
			hour_in_q   <= hour_id;
			value_in_q  <= sample_value;
			tag_in_q    <= sample_tag;
			charge_in_q <= charge_state;
			time_in_q   <= commit_time;
			index_in_q  <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_hour_q    <= '0;
			peak_value_q  <= '0;
			peak_tag_q    <= '0;
			peak_charge_q <= '0;
			pending_q     <= 1'b0;
			wr_slot_q     <= '0;
			wr_blk_q      <= '0;
			wr_off_q      <= '0;
			count_q       <= '0;
			used_q        <= '0;
			walk_q        <= '0;
			step_q        <= '0;
			found_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			used_q <= used_d;
			if (cmd.capture) begin
				done_q <= 1'b0;
			end else if (cmd.do_commit || cmd.rd_issue) begin
				done_q <= 1'b1;
			end
			if (cmd.do_sample) begin
				cur_hour_q    <= hour_in_q;
				peak_value_q  <= value_in_q;
				peak_tag_q    <= tag_in_q;
				peak_charge_q <= charge_in_q;
				pending_q     <= 1'b1;
			end else if (cmd.do_commit) begin
				cur_hour_q   <= '0;
				peak_value_q <= '0;
				pending_q    <= 1'b0;
				count_q      <= count_q + 1'b1;
				wr_slot_q    <= (wr_slot_q == SLOT_W'(TOTAL - 1)) ? '0 : wr_slot_q + 1'b1;
				if (wr_off_q == OFF_W'(SLOTS_PER_BLOCK - 1)) begin
					wr_off_q <= '0;
					wr_blk_q <= (wr_blk_q == BLK_W'(BLOCK_COUNT - 1)) ? '0 : wr_blk_q + 1'b1;
				end else begin
					wr_off_q <= wr_off_q + 1'b1;
				end
			end else if (cmd.do_clear) begin
				cur_hour_q    <= '0;
				peak_value_q  <= '0;
				peak_tag_q    <= '0;
				peak_charge_q <= '0;
				pending_q     <= 1'b0;
				wr_slot_q     <= '0;
				wr_blk_q      <= '0;
				wr_off_q      <= '0;
				count_q       <= '0;
			end
			if (cmd.walk_init) begin
				walk_q  <= (wr_slot_q == '0) ? SLOT_W'(TOTAL - 1) : wr_slot_q - 1'b1;
				step_q  <= '0;
				found_q <= '0;
			end else if (cmd.walk_step) begin
				walk_q <= (walk_q == '0) ? SLOT_W'(TOTAL - 1) : walk_q - 1'b1;
				step_q <= step_q + 1'b1;
				if (cmd.walk_count) begin
					found_q <= found_q + 1'b1;
				end
			end
		end
	end

	assign rec_sel = done_q && (req_q == hpel_pkg::REQ_READ);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			done_res     <= done_q;
			rec_time     <= rec_sel ? ram_rdata[RW-1 -: hpel_pkg::TIME_W] : '0;
			rec_value    <= rec_sel ? ram_rdata[3*BW +: hpel_pkg::VALUE_W] : '0;
			rec_type     <= rec_sel ? ram_rdata[2*BW +: BW] : '0;
			rec_cell     <= rec_sel ? ram_rdata[BW +: BW] : '0;
			rec_charge   <= rec_sel ? ram_rdata[0 +: BW] : '0;
			stored_count <= count_q;
			peak_pending <= pending_q;
		end
	end

endmodule

// ----- sv/hourly_peak_event_logger_unit.sv -----
// Hourly peak logger: holds the largest sample of the current hour (a forced update replaces it
// unconditionally) and, on a commit with a peak pending and fewer records than the record limit,
// writes it as a record into a ring of SLOTS_PER_BLOCK * BLOCK_COUNT slots, erasing the target
// block first if the slot is in use; a read returns the index-th newest stored record. One item
// is handled at a time and gives exactly one result. Update, forced update, commit, clear and
// unknown requests pass through the dispatch and finish states, and the next item is accepted
// once the controller is back in idle. A read walks the slot valid bits one slot per cycle from
// the newest backwards, stopping at the wanted record or after the last slot. The result sits in
// an output register, so the next item is accepted while it waits to be taken. The store needs
// no clearing pass after reset. Configuration registers sit at byte addresses 0 (channel
// mode), 4 (fixed event type) and 8 (record limit) and should only be written while idle.
module hourly_peak_event_logger_unit #(
	parameter int unsigned SLOTS_PER_BLOCK = hpel_pkg::SLOTS_PER_BLOCK_DEF,
	parameter int unsigned BLOCK_COUNT     = hpel_pkg::BLOCK_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hpel_pkg::PADDR_W-1:0]      paddr,
	input  logic [hpel_pkg::PDATA_W-1:0]      pwdata,
	output logic [hpel_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [hpel_pkg::REQ_W-1:0]        req_type,
	input  logic [hpel_pkg::HOUR_W-1:0]       hour_id,
	input  logic [hpel_pkg::VALUE_W-1:0]      sample_value,
	input  logic [hpel_pkg::BYTE_W-1:0]       sample_tag,
	input  logic [hpel_pkg::BYTE_W-1:0]       charge_state,
	input  logic [hpel_pkg::TIME_W-1:0]       commit_time,
	input  logic [hpel_pkg::INDEX_W-1:0]      read_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              done_res,
	output logic [hpel_pkg::TIME_W-1:0]       rec_time,
	output logic [hpel_pkg::VALUE_W-1:0]      rec_value,
	output logic [hpel_pkg::BYTE_W-1:0]       rec_type,
	output logic [hpel_pkg::BYTE_W-1:0]       rec_cell,
	output logic [hpel_pkg::BYTE_W-1:0]       rec_charge,
	output logic [hpel_pkg::COUNT_W-1:0]      stored_count,
	output logic                              peak_pending
);

	logic                         channel_mode_q;
	logic [hpel_pkg::BYTE_W-1:0]  fixed_type_q;
	logic [hpel_pkg::COUNT_W-1:0] record_limit_q;

	hpel_pkg::dp_cmd_t cmd;
	hpel_pkg::dp_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mode_q <= 1'b0;
			fixed_type_q   <= '0;
			record_limit_q <= hpel_pkg::RECORD_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				hpel_pkg::REG_CHANNEL_MODE: channel_mode_q <= pwdata[0];
				hpel_pkg::REG_FIXED_TYPE:   fixed_type_q   <= pwdata[hpel_pkg::BYTE_W-1:0];
				hpel_pkg::REG_RECORD_LIMIT: record_limit_q <= pwdata[hpel_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			hpel_pkg::REG_CHANNEL_MODE: prdata = hpel_pkg::PDATA_W'(channel_mode_q);
			hpel_pkg::REG_FIXED_TYPE:   prdata = hpel_pkg::PDATA_W'(fixed_type_q);
			hpel_pkg::REG_RECORD_LIMIT: prdata = hpel_pkg::PDATA_W'(record_limit_q);
			default:                    prdata = '0;
		endcase
	end

	hpel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	hpel_dp #(
		.SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
		.BLOCK_COUNT     (BLOCK_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.channel_mode     (channel_mode_q),
		.fixed_event_type (fixed_type_q),
		.record_limit     (record_limit_q),
		.req_type         (req_type),
		.hour_id          (hour_id),
		.sample_value     (sample_value),
		.sample_tag       (sample_tag),
		.charge_state     (charge_state),
		.commit_time      (commit_time),
		.read_index       (read_index),
		.done_res         (done_res),
		.rec_time         (rec_time),
		.rec_value        (rec_value),
		.rec_type         (rec_type),
		.rec_cell         (rec_cell),
		.rec_charge       (rec_charge),
		.stored_count     (stored_count),
		.peak_pending     (peak_pending)
	);

endmodule
